FILE: rtl/tpz_pkg.sv
// tpz_pkg: types, constants and small helper functions of the torus point splatter
// used by every module of the block; depends on nothing
`default_nettype none
package tpz_pkg;

    localparam int ROWS = 30;
    localparam int COLS = 100;
    localparam int CELLS = ROWS * COLS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

    localparam int FRAC_W = 14;
    localparam int HALF_DIV = 2;
    localparam int HALF_C = COLS / HALF_DIV;
    localparam int HALF_R = ROWS / HALF_DIV;
    localparam int SHADE_LEVELS = 11;
    localparam int LIGHT_SH = 3;
    localparam int LEVEL_SH = FRAC_W - LIGHT_SH;
    localparam int LEVEL_W = 9;

    localparam int DW = 24;
    localparam int NW = 32;
    localparam int DCNT_W = $clog2(NW);
    localparam logic [NW-1:0] RECIP_NUM = NW'(64'd1 << 28);
    localparam logic [15:0] RECIP_MAX = 16'hffff;
    localparam logic [6:0] CHAR_SPACE = 7'd32;

    localparam int CQ_DEPTH = 2;
    localparam int OQ_DEPTH = 2;

    localparam logic OP_SPLAT = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        REG_A_COS, REG_A_SIN, REG_B_COS, REG_B_SIN,
        REG_TUBE, REG_RING, REG_EYE, REG_SCALE
    } t_reg_idx;

    typedef struct packed {
        logic        operation;
        logic signed [15:0] theta_cos;
        logic signed [15:0] theta_sin;
        logic signed [15:0] phi_cos;
        logic signed [15:0] phi_sin;
        logic [4:0]  cell_row;
        logic [6:0]  cell_col;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cell_char;
        logic       drawn;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] rot_a_cos;
        logic signed [15:0] rot_a_sin;
        logic signed [15:0] rot_b_cos;
        logic signed [15:0] rot_b_sin;
        logic [2:0] tube_radius;
        logic [2:0] ring_radius;
        logic [3:0] eye_distance;
        logic [7:0] screen_scale;
    } t_cfg;

    typedef enum logic [1:0] {CMD_NOP, CMD_READ, CMD_SPLAT} t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [15:0]      recip;
        logic [3:0]       shade;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  shade;
        logic [15:0] depth;
    } t_cell;

    typedef struct packed {
        logic           start;
        logic [NW-1:0]  dividend;
        logic [DW-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [NW-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {F_IDLE, F_CALC, F_DIV, F_FINAL, F_PUSH} t_front_state;
    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_WB} t_back_state;
    typedef enum logic [1:0] {DIV_RECIP, DIV_COL, DIV_ROW} t_div_sel;

    typedef enum logic [4:0] {
        ST_AS_SP, ST_T0, ST_T1, ST_BC_CP, ST_X0, ST_X1, ST_BS_CP, ST_Y0, ST_Y1,
        ST_AC_SP, ST_Z0, ST_Z1, ST_AC_CT, ST_L0, ST_L1, ST_BC_AC, ST_L2,
        ST_BC_AS, ST_BCAS_CT, ST_L3, ST_BS_CT, ST_L4, ST_NC0, ST_NC1,
        ST_NR0, ST_NR1
    } t_step;

    function automatic logic [6:0] shade_char(input logic [3:0] code);
        logic [6:0] c;
        case (code)
            4'd1: c = 7'h2e;
            4'd2: c = 7'h2c;
            4'd3: c = 7'h2d;
            4'd4: c = 7'h7e;
            4'd5: c = 7'h3a;
            4'd6: c = 7'h3b;
            4'd7: c = 7'h3d;
            4'd8: c = 7'h21;
            4'd9: c = 7'h2a;
            4'd10: c = 7'h23;
            4'd11: c = 7'h24;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

    // level is below 512, so a few compares do the remainder
    function automatic logic [3:0] mod_levels(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] v;
        v = level;
        if (v >= LEVEL_W'(32 * SHADE_LEVELS)) v = v - LEVEL_W'(32 * SHADE_LEVELS);
        if (v >= LEVEL_W'(16 * SHADE_LEVELS)) v = v - LEVEL_W'(16 * SHADE_LEVELS);
        if (v >= LEVEL_W'(8 * SHADE_LEVELS)) v = v - LEVEL_W'(8 * SHADE_LEVELS);
        if (v >= LEVEL_W'(4 * SHADE_LEVELS)) v = v - LEVEL_W'(4 * SHADE_LEVELS);
        if (v >= LEVEL_W'(2 * SHADE_LEVELS)) v = v - LEVEL_W'(2 * SHADE_LEVELS);
        if (v >= LEVEL_W'(SHADE_LEVELS)) v = v - LEVEL_W'(SHADE_LEVELS);
        return v[3:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tpz_div.sv
// tpz_div: restoring unsigned divider, one quotient bit per cycle
// uses tpz_pkg for widths and request/response types
`default_nettype none
module tpz_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tpz_pkg::t_div_req i_req,
    output tpz_pkg::t_div_rsp      o_rsp
);
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [tpz_pkg::DCNT_W-1:0]    r_cnt, n_cnt;
    logic [tpz_pkg::DW-1:0]        r_rem, n_rem;
    logic [tpz_pkg::NW-1:0]        r_quo, n_quo;
    logic [tpz_pkg::DW-1:0]        r_dvs, n_dvs;
    logic [tpz_pkg::DW:0]          trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_quo[tpz_pkg::NW-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = tpz_pkg::DW'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[tpz_pkg::NW-2:0], 1'b1};
            end else begin
                n_rem = trial[tpz_pkg::DW-1:0];
                n_quo = {r_quo[tpz_pkg::NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == tpz_pkg::DCNT_W'(tpz_pkg::NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
endmodule
`default_nettype wire

FILE: rtl/tpz_queue.sv
// tpz_queue: two-entry command queue between front and back
// uses tpz_pkg for the command type and depth
`default_nettype none
module tpz_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tpz_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output tpz_pkg::t_cmd      o_data
);
    tpz_pkg::t_cmd r_mem [tpz_pkg::CQ_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == 2'(tpz_pkg::CQ_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

FILE: rtl/tpz_front.sv
// tpz_front: accepts items, runs the rotation and projection sequence on one
// shared multiplier and the divider, and issues cell commands; uses tpz_pkg
`default_nettype none
module tpz_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tpz_pkg::t_cfg     i_cfg,
    input  wire logic              i_push,
    input  wire tpz_pkg::t_in_item i_item,
    output logic                   o_full,
    output logic                   o_cmd_valid,
    output tpz_pkg::t_cmd          o_cmd,
    input  wire logic              i_cmd_full,
    output tpz_pkg::t_div_req      o_div,
    input  wire tpz_pkg::t_div_rsp i_div
);
    localparam int DW = tpz_pkg::DW;
    localparam int NW = tpz_pkg::NW;
    localparam int LW = tpz_pkg::LEVEL_W;

    tpz_pkg::t_front_state r_state, n_state;
    tpz_pkg::t_step        r_step, n_step;
    tpz_pkg::t_div_sel     r_sel, n_sel;
    logic                  r_start, n_start;
    tpz_pkg::t_cmd         r_cmd, n_cmd;

    logic signed [15:0]   r_ct, r_st, r_cp, r_sp, n_ct, n_st, n_cp, n_sp;
    logic signed [DW-1:0] r_cx, r_cy, r_t, r_x, r_y, r_z, r_lum, r_tmp;
    logic signed [DW-1:0] n_cx, n_cy, n_t, n_x, n_y, n_z, n_lum, n_tmp;
    logic signed [NW-1:0] r_nc, r_nr, n_nc, n_nr;
    logic [15:0]          r_recip, n_recip;
    logic [NW-1:0]        r_colq, r_rowq, n_colq, n_rowq;

    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [2*DW-1:0] prod;
    logic signed [DW-1:0]   q;
    logic signed [NW-1:0]   raw;
    logic signed [DW-1:0]   tube_s, ring_s, ct_s, st_s, eye_s;
    logic                   col_ok, row_ok, rd_ok;
    logic [LW-1:0]          level;

    assign prod = mul_a * mul_b;
    // floor back to Q14
    assign q    = DW'(prod >>> tpz_pkg::FRAC_W);
    assign raw  = NW'(prod);

    assign tube_s = DW'($signed({1'b0, i_cfg.tube_radius}));
    assign ring_s = DW'({i_cfg.ring_radius, 14'd0});
    assign eye_s  = DW'({i_cfg.eye_distance, 14'd0});
    assign ct_s   = DW'(i_item.theta_cos);
    assign st_s   = DW'(i_item.theta_sin);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            tpz_pkg::ST_AS_SP:   begin mul_a = DW'(i_cfg.rot_a_sin); mul_b = DW'(r_sp); end
            tpz_pkg::ST_T0:      begin mul_a = r_cy; mul_b = DW'(i_cfg.rot_a_cos); end
            tpz_pkg::ST_T1:      begin mul_a = r_tmp; mul_b = r_cx; end
            tpz_pkg::ST_BC_CP:   begin mul_a = DW'(i_cfg.rot_b_cos); mul_b = DW'(r_cp); end
            tpz_pkg::ST_X0:      begin mul_a = r_tmp; mul_b = r_cx; end
            tpz_pkg::ST_X1:      begin mul_a = DW'(i_cfg.rot_b_sin); mul_b = r_t; end
            tpz_pkg::ST_BS_CP:   begin mul_a = DW'(i_cfg.rot_b_sin); mul_b = DW'(r_cp); end
            tpz_pkg::ST_Y0:      begin mul_a = DW'(i_cfg.rot_b_cos); mul_b = r_t; end
            tpz_pkg::ST_Y1:      begin mul_a = r_tmp; mul_b = r_cx; end
            tpz_pkg::ST_AC_SP:   begin mul_a = DW'(i_cfg.rot_a_cos); mul_b = DW'(r_sp); end
            tpz_pkg::ST_Z0:      begin mul_a = r_tmp; mul_b = r_cx; end
            tpz_pkg::ST_Z1:      begin mul_a = r_cy; mul_b = DW'(i_cfg.rot_a_sin); end
            tpz_pkg::ST_AC_CT:   begin mul_a = DW'(i_cfg.rot_a_cos); mul_b = DW'(r_ct); end
            tpz_pkg::ST_L0:      begin mul_a = r_tmp; mul_b = DW'(r_sp); end
            tpz_pkg::ST_L1:      begin mul_a = DW'(i_cfg.rot_a_sin); mul_b = DW'(r_st); end
            tpz_pkg::ST_BC_AC:   begin
                mul_a = DW'(i_cfg.rot_b_cos);
                mul_b = DW'(i_cfg.rot_a_cos);
            end
            tpz_pkg::ST_L2:      begin mul_a = r_tmp; mul_b = DW'(r_st); end
            tpz_pkg::ST_BC_AS:   begin
                mul_a = DW'(i_cfg.rot_b_cos);
                mul_b = DW'(i_cfg.rot_a_sin);
            end
            tpz_pkg::ST_BCAS_CT: begin mul_a = r_tmp; mul_b = DW'(r_ct); end
            tpz_pkg::ST_L3:      begin mul_a = r_tmp; mul_b = DW'(r_sp); end
            tpz_pkg::ST_BS_CT:   begin mul_a = DW'(i_cfg.rot_b_sin); mul_b = DW'(r_ct); end
            tpz_pkg::ST_L4:      begin mul_a = r_tmp; mul_b = DW'(r_cp); end
            tpz_pkg::ST_NC0:     begin mul_a = DW'(tpz_pkg::HALF_C); mul_b = r_z; end
            tpz_pkg::ST_NC1:     begin mul_a = DW'(i_cfg.screen_scale); mul_b = r_x; end
            tpz_pkg::ST_NR0:     begin mul_a = DW'(tpz_pkg::HALF_R); mul_b = r_z; end
            tpz_pkg::ST_NR1:     begin mul_a = DW'(i_cfg.screen_scale); mul_b = r_y; end
            default:             begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // a negative numerator with zero quotient still lands on column or row 0
    assign col_ok = (!r_nc[NW-1] || r_colq == '0) && (r_colq < NW'(tpz_pkg::COLS));
    assign row_ok = (!r_nr[NW-1] || r_rowq == '0) && (r_rowq < NW'(tpz_pkg::ROWS));
    assign rd_ok  = (9'(i_item.cell_row) < 9'(tpz_pkg::ROWS))
                 && (9'(i_item.cell_col) < 9'(tpz_pkg::COLS));
    assign level  = r_lum[tpz_pkg::LEVEL_SH +: LW];

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sel   = r_sel;
        n_start = 1'b0;
        n_cmd   = r_cmd;
        n_ct = r_ct; n_st = r_st; n_cp = r_cp; n_sp = r_sp;
        n_cx = r_cx; n_cy = r_cy; n_t = r_t; n_x = r_x; n_y = r_y;
        n_z = r_z; n_lum = r_lum; n_tmp = r_tmp;
        n_nc = r_nc; n_nr = r_nr;
        n_recip = r_recip; n_colq = r_colq; n_rowq = r_rowq;
        o_full      = (r_state != tpz_pkg::F_IDLE);
        o_cmd_valid = 1'b0;
        unique case (r_state)
            tpz_pkg::F_IDLE: begin
                if (i_push) begin
                    n_ct = i_item.theta_cos;
                    n_st = i_item.theta_sin;
                    n_cp = i_item.phi_cos;
                    n_sp = i_item.phi_sin;
                    n_cx = ring_s + tube_s * ct_s;
                    n_cy = tube_s * st_s;
                    n_cmd       = '0;
                    n_cmd.kind  = tpz_pkg::CMD_NOP;
                    if (i_item.operation == tpz_pkg::OP_READ) begin
                        if (rd_ok) begin
                            n_cmd.kind = tpz_pkg::CMD_READ;
                            n_cmd.idx  = tpz_pkg::IDX_W'(32'(i_item.cell_row)
                                       * 32'(tpz_pkg::COLS) + 32'(i_item.cell_col));
                        end
                        n_state = tpz_pkg::F_PUSH;
                    end else begin
                        n_step  = tpz_pkg::ST_AS_SP;
                        n_state = tpz_pkg::F_CALC;
                    end
                end
            end
            tpz_pkg::F_CALC: begin
                n_step = tpz_pkg::t_step'(5'(r_step) + 5'd1);
                case (r_step)
                    tpz_pkg::ST_AS_SP:   n_tmp = q;
                    tpz_pkg::ST_T0:      n_t = q;
                    tpz_pkg::ST_T1:      n_t = r_t + q;
                    tpz_pkg::ST_BC_CP:   n_tmp = q;
                    tpz_pkg::ST_X0:      n_x = q;
                    tpz_pkg::ST_X1:      n_x = r_x + q;
                    tpz_pkg::ST_BS_CP:   n_tmp = q;
                    tpz_pkg::ST_Y0:      n_y = q;
                    tpz_pkg::ST_Y1:      n_y = r_y - q;
                    tpz_pkg::ST_AC_SP:   n_tmp = q;
                    tpz_pkg::ST_Z0:      n_z = eye_s + q;
                    tpz_pkg::ST_Z1:      n_z = r_z - q;
                    tpz_pkg::ST_AC_CT:   n_tmp = q;
                    tpz_pkg::ST_L0:      n_lum = -q;
                    tpz_pkg::ST_L1:      n_lum = r_lum + q;
                    tpz_pkg::ST_BC_AC:   n_tmp = q;
                    tpz_pkg::ST_L2:      n_lum = r_lum - q;
                    tpz_pkg::ST_BC_AS:   n_tmp = q;
                    tpz_pkg::ST_BCAS_CT: n_tmp = q;
                    tpz_pkg::ST_L3:      n_lum = r_lum - q;
                    tpz_pkg::ST_BS_CT:   n_tmp = q;
                    tpz_pkg::ST_L4:      n_lum = r_lum + q;
                    tpz_pkg::ST_NC0:     n_nc = raw;
                    tpz_pkg::ST_NC1:     n_nc = r_nc + raw;
                    tpz_pkg::ST_NR0:     n_nr = raw;
                    tpz_pkg::ST_NR1:     n_nr = r_nr - raw;
                    default:             n_tmp = r_tmp;
                endcase
                // point behind the eye, or dark point: nothing to draw
                if ((r_step == tpz_pkg::ST_AC_CT && r_z <= 0)
                    || (r_step == tpz_pkg::ST_NC0 && r_lum <= 0)) begin
                    n_cmd.kind = tpz_pkg::CMD_NOP;
                    n_state    = tpz_pkg::F_PUSH;
                end else if (r_step == tpz_pkg::ST_NR1) begin
                    n_sel   = tpz_pkg::DIV_RECIP;
                    n_start = 1'b1;
                    n_state = tpz_pkg::F_DIV;
                end
            end
            tpz_pkg::F_DIV: begin
                if (i_div.done) begin
                    unique case (r_sel)
                        tpz_pkg::DIV_RECIP: begin
                            n_recip = (i_div.quot > NW'(tpz_pkg::RECIP_MAX))
                                    ? tpz_pkg::RECIP_MAX : i_div.quot[15:0];
                            n_sel   = tpz_pkg::DIV_COL;
                            n_start = 1'b1;
                        end
                        tpz_pkg::DIV_COL: begin
                            n_colq  = i_div.quot;
                            n_sel   = tpz_pkg::DIV_ROW;
                            n_start = 1'b1;
                        end
                        tpz_pkg::DIV_ROW: begin
                            n_rowq  = i_div.quot;
                            n_state = tpz_pkg::F_FINAL;
                        end
                        default: n_state = tpz_pkg::F_FINAL;
                    endcase
                end
            end
            tpz_pkg::F_FINAL: begin
                if (col_ok && row_ok) begin
                    n_cmd.kind  = tpz_pkg::CMD_SPLAT;
                    n_cmd.idx   = tpz_pkg::IDX_W'(32'(r_rowq[tpz_pkg::ROW_W-1:0])
                                * 32'(tpz_pkg::COLS) + 32'(r_colq[tpz_pkg::COL_W-1:0]));
                    n_cmd.recip = r_recip;
                    n_cmd.shade = 4'd1 + tpz_pkg::mod_levels(level);
                end else begin
                    n_cmd.kind = tpz_pkg::CMD_NOP;
                end
                n_state = tpz_pkg::F_PUSH;
            end
            tpz_pkg::F_PUSH: begin
                o_cmd_valid = 1'b1;
                if (!i_cmd_full) n_state = tpz_pkg::F_IDLE;
            end
            default: n_state = tpz_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_div.start = r_start;
        o_div.divisor = r_z;
        unique case (r_sel)
            tpz_pkg::DIV_RECIP: o_div.dividend = tpz_pkg::RECIP_NUM;
            tpz_pkg::DIV_COL:   o_div.dividend = r_nc[NW-1] ? NW'(-r_nc) : NW'(r_nc);
            tpz_pkg::DIV_ROW:   o_div.dividend = r_nr[NW-1] ? NW'(-r_nr) : NW'(r_nr);
            default:            o_div.dividend = '0;
        endcase
    end

    assign o_cmd = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpz_pkg::F_IDLE;
            r_step  <= tpz_pkg::ST_AS_SP;
            r_sel   <= tpz_pkg::DIV_RECIP;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sel   <= n_sel;
            r_start <= n_start;
        end
        r_cmd <= n_cmd;
        r_ct <= n_ct; r_st <= n_st; r_cp <= n_cp; r_sp <= n_sp;
        r_cx <= n_cx; r_cy <= n_cy; r_t <= n_t; r_x <= n_x; r_y <= n_y;
        r_z <= n_z; r_lum <= n_lum; r_tmp <= n_tmp;
        r_nc <= n_nc; r_nr <= n_nr;
        r_recip <= n_recip; r_colq <= n_colq; r_rowq <= n_rowq;
    end
endmodule
`default_nettype wire

FILE: rtl/tpz_back.sv
// tpz_back: cell memory with clearing pass, read-modify-write of commands and
// the two-word result queue; uses tpz_pkg
`default_nettype none
module tpz_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire tpz_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_clearing,
    input  wire logic          i_pop,
    output logic               o_empty,
    output tpz_pkg::t_out_item o_result
);
    localparam int IW = tpz_pkg::IDX_W;

    tpz_pkg::t_cell       mem [tpz_pkg::CELLS];
    tpz_pkg::t_cell       r_rdata;
    tpz_pkg::t_back_state r_state, n_state;
    logic [IW-1:0]        r_clr, n_clr;
    tpz_pkg::t_cmd        r_cmd, n_cmd;

    tpz_pkg::t_out_item   r_oq [tpz_pkg::OQ_DEPTH];
    logic                 r_owp, r_orp;
    logic [1:0]           r_ocnt;
    logic                 o_push, o_do_pop;
    tpz_pkg::t_out_item   res;

    logic                 we, re;
    logic [IW-1:0]        waddr;
    tpz_pkg::t_cell       wdata;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cmd      = r_cmd;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = r_cmd.idx;
        wdata      = '0;
        o_cmd_pop  = 1'b0;
        o_push     = 1'b0;
        res.cell_char = tpz_pkg::CHAR_SPACE;
        res.drawn     = 1'b0;
        unique case (r_state)
            tpz_pkg::B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                if (r_clr == IW'(tpz_pkg::CELLS - 1)) n_state = tpz_pkg::B_IDLE;
                else n_clr = r_clr + 1'b1;
            end
            tpz_pkg::B_IDLE: begin
                if (i_cmd_valid && r_ocnt != 2'(tpz_pkg::OQ_DEPTH)) begin
                    o_cmd_pop = 1'b1;
                    re        = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = tpz_pkg::B_WB;
                end
            end
            tpz_pkg::B_WB: begin
                o_push = 1'b1;
                case (r_cmd.kind)
                    tpz_pkg::CMD_READ: begin
                        res.cell_char = tpz_pkg::shade_char(r_rdata.shade);
                        we = 1'b1;
                    end
                    tpz_pkg::CMD_SPLAT: begin
                        if (r_cmd.recip > r_rdata.depth) begin
                            we          = 1'b1;
                            wdata.shade = r_cmd.shade;
                            wdata.depth = r_cmd.recip;
                            res.drawn   = 1'b1;
                        end
                    end
                    default: we = 1'b0;
                endcase
                n_state = tpz_pkg::B_IDLE;
            end
            default: n_state = tpz_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (re) r_rdata <= mem[i_cmd.idx];
    end

    assign o_do_pop   = i_pop && (r_ocnt != 2'd0);
    assign o_empty    = (r_ocnt == 2'd0);
    assign o_result   = r_oq[r_orp];
    assign o_clearing = (r_state == tpz_pkg::B_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpz_pkg::B_CLEAR;
            r_clr   <= '0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (o_push) r_owp <= ~r_owp;
            if (o_do_pop) r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(o_push) - 2'(o_do_pop);
        end
        r_cmd <= n_cmd;
        if (o_push) r_oq[r_owp] <= res;
    end
endmodule
`default_nettype wire

FILE: rtl/torus_point_zbuffer_splat.sv
// torus_point_zbuffer_splat: top level, configuration registers and wiring
// depends on tpz_pkg, tpz_front, tpz_div, tpz_queue, tpz_back
//
// Input channel: an item is taken when push is high and full is low. A splat
// item rotates and projects one torus point and may update one cell of the
// 30 x 100 z-buffer; a read item returns the cell's character and clears it.
// Every item yields exactly one result word, in order, on o_result while
// empty is low; pop takes it.
// A read item goes straight to the command queue and then to the read and
// write-back of its cell. A splat item takes 26 steps on the single shared
// multiplier, then three divisions (reciprocal depth, column, row) on the
// bit-serial divider, then the read-modify-write of the cell memory. A point
// dropped early finishes sooner. The front takes no new item before it has
// handed the command of the last one to the command queue.
// After reset full stays high while the cell memory is cleared, one cell per
// cycle. A stalled receiver fills the two-word result queue and the two-word
// command queue, after which full holds the input. Registers must be written
// over the APB port only while the block is idle; the block itself does not
// enforce this.
`default_nettype none
module torus_point_zbuffer_splat (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire tpz_pkg::t_in_item i_item,
    output logic                   empty,
    input  wire logic              pop,
    output tpz_pkg::t_out_item     o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    tpz_pkg::t_cfg     r_cfg;
    tpz_pkg::t_reg_idx reg_idx;
    tpz_pkg::t_div_req div_req;
    tpz_pkg::t_div_rsp div_rsp;
    tpz_pkg::t_cmd     f_cmd, q_cmd;
    logic              f_full, f_cmd_valid, q_full, q_valid, b_pop, clearing;

    assign pready  = 1'b1;
    assign reg_idx = tpz_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_a_cos    <= 16'sd16384;
            r_cfg.rot_a_sin    <= 16'sd0;
            r_cfg.rot_b_cos    <= 16'sd16384;
            r_cfg.rot_b_sin    <= 16'sd0;
            r_cfg.tube_radius  <= 3'd1;
            r_cfg.ring_radius  <= 3'd2;
            r_cfg.eye_distance <= 4'd5;
            r_cfg.screen_scale <= 8'd12;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                tpz_pkg::REG_A_COS: r_cfg.rot_a_cos    <= pwdata[15:0];
                tpz_pkg::REG_A_SIN: r_cfg.rot_a_sin    <= pwdata[15:0];
                tpz_pkg::REG_B_COS: r_cfg.rot_b_cos    <= pwdata[15:0];
                tpz_pkg::REG_B_SIN: r_cfg.rot_b_sin    <= pwdata[15:0];
                tpz_pkg::REG_TUBE:  r_cfg.tube_radius  <= pwdata[2:0];
                tpz_pkg::REG_RING:  r_cfg.ring_radius  <= pwdata[2:0];
                tpz_pkg::REG_EYE:   r_cfg.eye_distance <= pwdata[3:0];
                tpz_pkg::REG_SCALE: r_cfg.screen_scale <= pwdata[7:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tpz_pkg::REG_A_COS: prdata = 32'(r_cfg.rot_a_cos);
            tpz_pkg::REG_A_SIN: prdata = 32'(r_cfg.rot_a_sin);
            tpz_pkg::REG_B_COS: prdata = 32'(r_cfg.rot_b_cos);
            tpz_pkg::REG_B_SIN: prdata = 32'(r_cfg.rot_b_sin);
            tpz_pkg::REG_TUBE:  prdata = 32'(r_cfg.tube_radius);
            tpz_pkg::REG_RING:  prdata = 32'(r_cfg.ring_radius);
            tpz_pkg::REG_EYE:   prdata = 32'(r_cfg.eye_distance);
            tpz_pkg::REG_SCALE: prdata = 32'(r_cfg.screen_scale);
            default:            prdata = '0;
        endcase
    end

    // no item enters during the memory clearing pass
    assign full = f_full || clearing;

    tpz_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push && !clearing),
        .i_item      (i_item),
        .o_full      (f_full),
        .o_cmd_valid (f_cmd_valid),
        .o_cmd       (f_cmd),
        .i_cmd_full  (q_full),
        .o_div       (div_req),
        .i_div       (div_rsp)
    );

    tpz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tpz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_cmd_valid),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    tpz_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (b_pop),
        .o_clearing  (clearing),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );
endmodule
`default_nettype wire

FILE: rtl/tpz_checker.sv
// tpz_checker: port-level assertions for torus_point_zbuffer_splat, with bind
// depends on tpz_pkg for the result type
`default_nettype none
module tpz_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic               pready,
    input wire tpz_pkg::t_out_item o_result
);
    // reset starts the clearing pass, so no item may enter right after it
    a_full_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low right after reset");

    a_empty_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // a drawn splat never carries a character
    a_drawn_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.drawn) |-> (o_result.cell_char == tpz_pkg::CHAR_SPACE))
        else $error("drawn word with a character");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result word changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");
endmodule

bind torus_point_zbuffer_splat tpz_checker u_tpz_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .pready   (pready),
    .o_result (o_result)
);
`default_nettype wire
